/* rtl/lcg_rir_pkg.sv */
// Package for the range-scaled LCG random generator.
// Holds the controller state type, the command bundle and the generator constants.
// No dependencies; used by lcg_rir_ctrl, lcg_rir_dp and lcg_random_in_range.
package lcg_rir_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned RAW_W  = 31;

  localparam logic [DATA_W-1:0] LCG_MUL    = 32'd1103515245;
  localparam logic [DATA_W-1:0] LCG_ADD    = 32'd12345;
  localparam logic [DATA_W-1:0] SEED_RESET = 32'd1;
  localparam logic [RAW_W-1:0]  RAW_MAX    = 31'h7FFF_FFFF;

  // Controller sequence: three generator steps, scale multiply, two fold steps
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP1,
    ST_STEP2,
    ST_STEP3,
    ST_SCALE,
    ST_FOLD,
    ST_QUOT,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic lcg_step;
    logic first_step;
    logic scale_mul;
    logic fold;
    logic quot;
    logic load_out;
  } cmd_t;

endpackage

/* rtl/lcg_rir_ctrl.sv */
// Controller of the range-scaled LCG generator: sequences one request at a time
// through the shared-multiplier datapath and owns the output valid flag.
// Depends on lcg_rir_pkg.
module lcg_rir_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output lcg_rir_pkg::cmd_t cmd
);

  lcg_rir_pkg::state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  // State and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcg_rir_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      lcg_rir_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = lcg_rir_pkg::ST_STEP1;
        end
      end
      lcg_rir_pkg::ST_STEP1: begin
        cmd.lcg_step   = 1'b1;
        cmd.first_step = 1'b1;
        state_nxt      = lcg_rir_pkg::ST_STEP2;
      end
      lcg_rir_pkg::ST_STEP2: begin
        cmd.lcg_step = 1'b1;
        state_nxt    = lcg_rir_pkg::ST_STEP3;
      end
      lcg_rir_pkg::ST_STEP3: begin
        cmd.lcg_step = 1'b1;
        state_nxt    = lcg_rir_pkg::ST_SCALE;
      end
      lcg_rir_pkg::ST_SCALE: begin
        cmd.scale_mul = 1'b1;
        state_nxt     = lcg_rir_pkg::ST_FOLD;
      end
      lcg_rir_pkg::ST_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = lcg_rir_pkg::ST_QUOT;
      end
      lcg_rir_pkg::ST_QUOT: begin
        cmd.quot  = 1'b1;
        state_nxt = lcg_rir_pkg::ST_DONE;
      end
      lcg_rir_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = lcg_rir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lcg_rir_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when the result is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_tready  = (state_r == lcg_rir_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

/* rtl/lcg_rir_dp.sv */
// Datapath of the range-scaled LCG generator: generator state, one shared
// 32x32 multiplier, and the fold steps that divide by 2^31-1.
// Depends on lcg_rir_pkg.
module lcg_rir_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lcg_rir_pkg::cmd_t                      cmd,
  input  logic                                   cfg_we,
  input  logic [lcg_rir_pkg::DATA_W-1:0]         cfg_wdata,
  input  logic [lcg_rir_pkg::DATA_W-1:0]         range_low,
  input  logic [lcg_rir_pkg::DATA_W-1:0]         range_high,
  output logic [lcg_rir_pkg::DATA_W-1:0]         scaled_value,
  output logic [lcg_rir_pkg::RAW_W-1:0]          raw_value
);

  logic [31:0] state_r, state_nxt;
  logic [30:0] raw_r;
  logic [31:0] lo_r;
  logic [31:0] mag_r;
  logic        neg_r;
  logic [62:0] prod_r;
  logic [32:0] fold_r;
  logic [31:0] quot_r;
  logic [31:0] out_scaled_r;
  logic [30:0] out_raw_r;

  logic [32:0] diff;
  logic [32:0] diff_abs;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] mul_full;
  logic [32:0] fold_sum;
  logic [1:0]  fold_hi;
  logic [31:0] fold_lo;
  logic        fold_corr;
  logic [31:0] quot_sum;
  logic [31:0] res;

  // Range difference, kept as sign and magnitude
  assign diff     = {range_high[31], range_high} - {range_low[31], range_low};
  assign diff_abs = diff[32] ? (~diff + 33'd1) : diff;

  // Shared multiplier: generator step or scaling product
  assign op_a     = cmd.scale_mul ? mag_r : state_r;
  assign op_b     = cmd.scale_mul ? {1'b0, raw_r} : lcg_rir_pkg::LCG_MUL;
  assign mul_full = {32'b0, op_a} * {32'b0, op_b};
  assign state_nxt = mul_full[31:0] + lcg_rir_pkg::LCG_ADD;

  // Divide by 2^31-1: P = a*2^31 + b folds to a + (a + b), then once more
  assign fold_sum  = {1'b0, prod_r[62:31]} + {2'b0, prod_r[30:0]};
  assign fold_hi   = fold_r[32:31];
  assign fold_lo   = {1'b0, fold_r[30:0]} + {30'b0, fold_hi};
  assign fold_corr = (fold_lo >= {1'b0, lcg_rir_pkg::RAW_MAX});
  assign quot_sum  = prod_r[62:31] + {30'b0, fold_hi} + {31'b0, fold_corr};

  // Apply sign of the difference and offset by the lower end
  assign res = neg_r ? (lo_r - quot_r) : (lo_r + quot_r);

  // Generator state: reset to one, reload on seed write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcg_rir_pkg::SEED_RESET;
    end else if (cfg_we) begin
      state_r <= cfg_wdata;
    end else if (cmd.lcg_step) begin
      state_r <= state_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      lo_r  <= range_low;
      mag_r <= diff_abs[31:0];
      neg_r <= diff[32];
    end
    if (cmd.lcg_step) begin
      if (cmd.first_step) begin
        raw_r <= {20'b0, state_nxt[26:16]};
      end else begin
        raw_r <= {raw_r[20:0], state_nxt[25:16]};
      end
    end
    if (cmd.scale_mul) begin
      prod_r <= mul_full[62:0];
    end
    if (cmd.fold) begin
      fold_r <= fold_sum;
    end
    if (cmd.quot) begin
      quot_r <= quot_sum;
    end
    if (cmd.load_out) begin
      out_scaled_r <= res;
      out_raw_r    <= raw_r;
    end
  end

  assign scaled_value = out_scaled_r;
  assign raw_value    = out_raw_r;

endmodule

/* rtl/lcg_random_in_range.sv */
// Top level of the range-scaled LCG random generator.
// Instantiates lcg_rir_ctrl and lcg_rir_dp; depends on lcg_rir_pkg.
//
//   Channel  Dir  Width  Contents
//   in_      in   64     range_low, range_high (signed Q16.16)
//   out_     out  64     scaled_value (signed Q16.16), raw_value, one zero pad bit
//   cfg_     in   32     seed; a write reloads the generator state
//
// A request runs to the result at out_ in steps set by the one shared multiplier:
// three generator steps, one scaling product, then fold and quotient steps for the
// divide by 2^31-1, offset added at load. in_tready is high only while no request is
// in work, so a new request is taken only after the last is in the output register.
// A result held by low out_tready does not block acceptance; the next request waits
// in ST_DONE. Reset (rst_n low, synchronous) clears control, state one.
module lcg_random_in_range (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] range_low, [63:32] range_high
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] scaled_value, [62:32] raw_value, [63] zero
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  lcg_rir_pkg::cmd_t cmd;
  logic [31:0]       scaled_value;
  logic [30:0]       raw_value;

  lcg_rir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd)
  );

  lcg_rir_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .range_low   (in_tdata[31:0]),
    .range_high  (in_tdata[63:32]),
    .scaled_value(scaled_value),
    .raw_value   (raw_value)
  );

  assign out_tdata = {1'b0, raw_value, scaled_value};

endmodule

/* rtl/lcg_rir_chk.sv */
// Port-level checker for lcg_random_in_range, attached by bind.
// Depends only on the top-level ports.
module lcg_rir_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // Reset leaves the block empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not empty after reset");

  // Drop ready once a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request accepted while busy");

  // A result is loaded in ST_DONE after acceptance and then shows at out_tvalid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##8 out_tvalid)
    else $error("no result eight edges after request");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind lcg_random_in_range lcg_rir_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

/* test/lcg_random_in_range_tb.sv */
// Self-checking testbench for lcg_random_in_range: directed range ends, then random ranges
// under several seeds and idle patterns, checked against a behavioral prediction.
// Depends on lcg_rir_pkg and the lcg_random_in_range RTL.
module lcg_random_in_range_tb;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [31:0] Q_MIN       = 32'h8000_0000;
  localparam logic [31:0] Q_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_ONE       = 32'h0001_0000;

  // Prediction of the generator plus the list of draws still owed by the block
  class range_draw_book;
    logic [31:0] gen_state;
    logic [63:0] draws_due[$];
    int unsigned failures;

    function new();
      gen_state = lcg_rir_pkg::SEED_RESET;
      failures  = 0;
    endfunction

    function logic [31:0] lcg_next(logic [31:0] s);
      return s * lcg_rir_pkg::LCG_MUL + lcg_rir_pkg::LCG_ADD;
    endfunction

    function void load_seed(logic [31:0] s);
      gen_state = s;
    endfunction

    function int unsigned pending();
      return draws_due.size();
    endfunction

    // Advance three steps, build the raw draw and scale it between the ends
    function void predict_draw(logic [31:0] lo, logic [31:0] hi);
      logic [31:0] s1, s2, s3;
      logic [30:0] raw;
      longint lo_w, diff, raw_w, prod, quot, res;
      s1 = lcg_next(gen_state);
      s2 = lcg_next(s1);
      s3 = lcg_next(s2);
      gen_state = s3;
      raw   = {s1[26:16], s2[25:16], s3[25:16]};
      lo_w  = $signed({{32{lo[31]}}, lo});
      diff  = $signed({{32{hi[31]}}, hi}) - lo_w;
      raw_w = {33'b0, raw};
      prod  = diff * raw_w;
      quot  = prod / 64'sd2147483647;
      res   = lo_w + quot;
      draws_due.push_back({1'b0, raw, res[31:0]});
    endfunction

    function void note_failure(string what, logic [63:0] want, logic [63:0] got);
      if (failures < MAX_REPORTS)
        $display("mismatch (%s): expected scaled %h raw %h, got scaled %h raw %h",
                 what, want[31:0], want[62:32], got[31:0], got[62:32]);
      failures++;
    endfunction

    // Compare a returned draw with the oldest one owed
    function void check_draw(logic [63:0] got);
      logic [63:0] want;
      if (draws_due.size() == 0) begin
        note_failure("no request pending", 64'b0, got);
      end else begin
        want = draws_due.pop_front();
        if (got[31:0] !== want[31:0])
          note_failure("scaled_value", want, got);
        if (got[62:32] !== want[62:32])
          note_failure("raw_value", want, got);
      end
    endfunction

    // Find a seed whose first request draws the largest or smallest raw value in a search
    function logic [31:0] extreme_seed(bit want_max);
      logic [31:0] inv, s1, s2, s3, best_s1;
      logic [30:0] raw, best;
      logic [16:0] k;
      inv = lcg_rir_pkg::LCG_MUL;
      repeat (5) inv = inv * (32'd2 - lcg_rir_pkg::LCG_MUL * inv);
      best    = want_max ? '0 : '1;
      best_s1 = {5'b0, {11{want_max}}, 16'b0};
      for (k = 0; k < 17'h10000; k++) begin
        s1  = {5'b0, {11{want_max}}, k[15:0]};
        s2  = lcg_next(s1);
        s3  = lcg_next(s2);
        raw = {s1[26:16], s2[25:16], s3[25:16]};
        if (want_max ? (raw > best) : (raw < best)) begin
          best    = raw;
          best_s1 = s1;
        end
      end
      return (best_s1 - lcg_rir_pkg::LCG_ADD) * inv;
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [31:0] cfg_wdata  = '0;

  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   quiet_cycles   = 0;
  range_draw_book book;

  lcg_random_in_range uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Check results, stall the receiver and watch for a hang
  always @(posedge clk) begin
    if (out_tvalid && out_tready)
      book.check_draw(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Present one request after a random gap and hold it until accepted
  task automatic send_range(input logic [31:0] lo, input logic [31:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hi, lo};
    do @(posedge clk); while (!in_tready);
    book.predict_draw(lo, hi);
  endtask

  // Drop the request line and wait until every draw has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  // Write the seed register while the block is idle
  task automatic write_seed(input logic [31:0] s);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.load_seed(s);
  endtask

  // Range end: mostly full-width random, with extremes and small Q16.16 values
  function automatic logic [31:0] pick_end();
    case ($urandom_range(7))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return $urandom_range(32'h3_FFFF) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] top_seed, bottom_seed, lo, hi;
    book = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    top_seed    = book.extreme_seed(1'b1);
    bottom_seed = book.extreme_seed(1'b0);

    // Directed: reset seed, extreme, equal and reversed ends
    send_range(Q_MIN, Q_MAX);
    send_range(Q_MAX, Q_MIN);
    send_range(32'h0, 32'h0);
    send_range(Q_MAX, Q_MAX);
    send_range(Q_MIN, Q_MIN);
    send_range(32'h0, Q_MAX);
    send_range(Q_MIN, 32'h0);
    send_range(32'hFFFF_FFFF, 32'h0);
    send_range(Q_ONE, 32'h0002_0000);
    send_range(32'h0005_0000, 32'hFFFB_0000);
    send_range(32'h1, 32'h2);
    send_range(Q_MAX, 32'h7FFF_FFFE);

    // Directed: raw draw at its top and bottom, then the seed extremes
    write_seed(top_seed);
    send_range(Q_MIN, Q_MAX);
    send_range(32'h0, Q_ONE);
    write_seed(top_seed);
    send_range(Q_MAX, Q_MIN);
    write_seed(bottom_seed);
    send_range(Q_MIN, Q_MAX);
    write_seed(32'h0);
    send_range(Q_MIN, Q_MAX);
    send_range(32'h1234_5678, 32'h1234_5678);
    write_seed(32'hFFFF_FFFF);
    send_range(Q_MIN, Q_MAX);
    send_range(Q_MAX, Q_MIN);

    // Random ranges over several seeds and idle patterns
    for (int p = 0; p < 8; p++) begin
      if (p == 3)
        write_seed(32'h0);
      else if (p == 6)
        write_seed(32'hFFFF_FFFF);
      else
        write_seed($urandom);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      repeat (206) begin
        lo = pick_end();
        hi = ($urandom_range(9) == 0) ? lo : pick_end();
        send_range(lo, hi);
      end
    end

    // Let the last draws return, then allow the pipeline to settle
    drain();
    repeat (10) @(posedge clk);
    if (book.failures == 0 && book.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
